// ===== sv/sfla_pkg.sv =====
// shared types, constants and command/status structs for the segregated free-list allocator
// no dependencies
`default_nettype none

package sfla_pkg;

    localparam int NUM_CLASSES_DEF = 512;
    localparam int GRANULE_BYTES   = 16;
    localparam int GRAN_SHIFT      = $clog2(GRANULE_BYTES);
    localparam int HEAP_GRANULES   = 65536;

    localparam int LEN_W  = 13;
    localparam int BLK_W  = 16;
    localparam int CNT_W  = 16;
    localparam int HEAP_W = 17;
    localparam int CLS_W  = LEN_W - GRAN_SHIFT;
    localparam int LINK_DEPTH = 2 ** BLK_W;

    // bump limit cap from the heap size and the link store depth
    localparam logic [HEAP_W-1:0] HEAP_LIMIT =
        HEAP_W'((HEAP_GRANULES < LINK_DEPTH) ? HEAP_GRANULES : LINK_DEPTH);
    localparam logic [HEAP_W-1:0] HEAP_END_RST = HEAP_W'(65536);
    localparam logic [HEAP_W-1:0] BUMP_RST     = HEAP_W'(1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADLEN = 2'd1,
        ST_FULL   = 2'd2,
        ST_NULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_POP,
        S_APPEND,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        RES_NULL,
        RES_BADLEN,
        RES_FULL,
        RES_BUMP,
        RES_REUSE,
        RES_FREE
    } res_sel_t;

    typedef struct packed {
        logic [BLK_W-1:0] head;
        logic [BLK_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } class_row_t;

    typedef struct packed {
        logic     clear_wr;
        logic     accept;
        logic     link_rd;
        logic     link_wr_zero;
        logic     link_wr_tail;
        logic     class_wr_pop;
        logic     class_wr_push;
        logic     bump_take;
        logic     res_load;
        res_sel_t res_sel;
        logic     push_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic null_blk;
        logic bad_len;
        logic count_zero;
        logic bump_fits;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/sfla_ctrl.sv =====
// controller state machine for the segregated free-list allocator
// depends on sfla_pkg
`default_nettype none

module sfla_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sfla_pkg::dp_stat_t stat,
    output sfla_pkg::dp_cmd_t       cmd
);

    sfla_pkg::state_t state_reg;
    sfla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfla_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfla_pkg::S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = sfla_pkg::S_IDLE;
                end
            end
            sfla_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfla_pkg::S_LOOKUP;
                end
            end
            sfla_pkg::S_LOOKUP:
            begin
                if (stat.is_free && stat.null_blk)
                begin
                    state_next = sfla_pkg::S_FINISH;
                end
                else if (stat.bad_len)
                begin
                    state_next = sfla_pkg::S_FINISH;
                end
                else if (stat.is_free)
                begin
                    state_next = sfla_pkg::S_APPEND;
                end
                else if (!stat.count_zero)
                begin
                    state_next = sfla_pkg::S_POP;
                end
                else
                begin
                    state_next = sfla_pkg::S_FINISH;
                end
            end
            sfla_pkg::S_POP,
            sfla_pkg::S_APPEND:
            begin
                state_next = sfla_pkg::S_FINISH;
            end
            sfla_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = in_valid ? sfla_pkg::S_LOOKUP : sfla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfla_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sfla_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            sfla_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            sfla_pkg::S_LOOKUP:
            begin
                cmd.res_load = 1'b1;
                if (stat.is_free && stat.null_blk)
                begin
                    cmd.res_sel = sfla_pkg::RES_NULL;
                end
                else if (stat.bad_len)
                begin
                    cmd.res_sel = sfla_pkg::RES_BADLEN;
                end
                else if (stat.is_free)
                begin
                    cmd.res_sel      = sfla_pkg::RES_FREE;
                    cmd.link_wr_zero = 1'b1;
                end
                else if (!stat.count_zero)
                begin
                    cmd.res_sel = sfla_pkg::RES_REUSE;
                    cmd.link_rd = 1'b1;
                end
                else if (stat.bump_fits)
                begin
                    cmd.res_sel   = sfla_pkg::RES_BUMP;
                    cmd.bump_take = 1'b1;
                end
                else
                begin
                    cmd.res_sel = sfla_pkg::RES_FULL;
                end
            end
            sfla_pkg::S_POP:
            begin
                cmd.class_wr_pop = 1'b1;
            end
            sfla_pkg::S_APPEND:
            begin
                cmd.class_wr_push = 1'b1;
                cmd.link_wr_tail  = !stat.count_zero;
            end
            sfla_pkg::S_FINISH:
            begin
                cmd.push_out = stat.out_free;
                in_ready     = stat.out_free;
                cmd.accept   = stat.out_free && in_valid;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sfla_datapath.sv =====
// datapath: class table memory, link store, bump pointer, result and output registers
// depends on sfla_pkg
`default_nettype none

module sfla_datapath #(
    parameter int NUM_CLASSES = sfla_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sfla_pkg::dp_cmd_t             cmd,
    output sfla_pkg::dp_stat_t                 stat,
    input  wire logic                          op,
    input  wire logic [sfla_pkg::LEN_W-1:0]    length,
    input  wire logic [sfla_pkg::BLK_W-1:0]    block,
    input  wire logic                          cfg_we,
    input  wire logic [sfla_pkg::HEAP_W-1:0]   cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sfla_pkg::BLK_W-1:0]         granted,
    output logic                               reused,
    output logic [1:0]                         status
);

    localparam int AW    = $clog2(NUM_CLASSES);
    localparam int SUM_W = sfla_pkg::HEAP_W + 1;

    // latched request
    logic                         op_reg;
    logic [sfla_pkg::LEN_W-1:0]   length_reg;
    logic [sfla_pkg::BLK_W-1:0]   block_reg;

    logic [sfla_pkg::CLS_W-1:0]   cls;
    logic [AW-1:0]                cls_addr;
    logic [AW-1:0]                in_addr;

    // class table: head, tail, count per class
    sfla_pkg::class_row_t         class_mem [NUM_CLASSES];
    sfla_pkg::class_row_t         class_rd_reg;
    sfla_pkg::class_row_t         class_wdata;
    logic [AW-1:0]                class_waddr;
    logic                         class_we;
    logic [AW-1:0]                clear_cnt_reg;

    // link store
    logic [sfla_pkg::BLK_W-1:0]   link_mem [sfla_pkg::LINK_DEPTH];
    logic [sfla_pkg::BLK_W-1:0]   link_rd_reg;
    logic [sfla_pkg::BLK_W-1:0]   link_waddr;
    logic [sfla_pkg::BLK_W-1:0]   link_wdata;
    logic                         link_we;

    // bump allocator
    logic [sfla_pkg::HEAP_W-1:0]  bump_reg;
    logic [sfla_pkg::HEAP_W-1:0]  heap_end_reg;
    logic [sfla_pkg::HEAP_W-1:0]  limit;
    logic [SUM_W-1:0]             bump_sum;

    // pending result and output register
    logic [sfla_pkg::BLK_W-1:0]   res_granted_reg;
    logic                         res_reused_reg;
    sfla_pkg::status_t            res_status_reg;
    logic                         out_valid_reg;
    logic [sfla_pkg::BLK_W-1:0]   out_granted_reg;
    logic                         out_reused_reg;
    sfla_pkg::status_t            out_status_reg;

    assign cls      = length_reg[sfla_pkg::LEN_W-1:sfla_pkg::GRAN_SHIFT];
    assign cls_addr = AW'(cls);
    assign in_addr  = AW'(length[sfla_pkg::LEN_W-1:sfla_pkg::GRAN_SHIFT]);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= op;
            length_reg <= length;
            block_reg  <= block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clear_cnt_reg <= clear_cnt_reg + AW'(1);
        end
    end

    always_comb
    begin
        class_we    = cmd.clear_wr || cmd.class_wr_pop || cmd.class_wr_push;
        class_waddr = cmd.clear_wr ? clear_cnt_reg : cls_addr;
        class_wdata = '0;
        if (cmd.class_wr_pop)
        begin
            class_wdata.head  = link_rd_reg;
            class_wdata.tail  = class_rd_reg.tail;
            class_wdata.count = class_rd_reg.count - sfla_pkg::CNT_W'(1);
        end
        else if (cmd.class_wr_push)
        begin
            class_wdata.head  = (class_rd_reg.count == '0) ? block_reg : class_rd_reg.head;
            class_wdata.tail  = block_reg;
            class_wdata.count = (class_rd_reg.count == '1) ? class_rd_reg.count
                                : class_rd_reg.count + sfla_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (class_we)
        begin
            class_mem[class_waddr] <= class_wdata;
        end
        if (cmd.accept)
        begin
            class_rd_reg <= class_mem[in_addr];
        end
    end

    // zero the freed block's link first, then hook it behind the old tail if the class was not empty
    assign link_we    = cmd.link_wr_zero || cmd.link_wr_tail;
    assign link_waddr = cmd.link_wr_zero ? block_reg : class_rd_reg.tail;
    assign link_wdata = cmd.link_wr_zero ? '0 : block_reg;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.link_rd)
        begin
            link_rd_reg <= link_mem[class_rd_reg.head];
        end
    end

    assign limit    = (heap_end_reg > sfla_pkg::HEAP_LIMIT) ? sfla_pkg::HEAP_LIMIT
                      : heap_end_reg;
    assign bump_sum = SUM_W'(bump_reg) + SUM_W'(cls) + SUM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg     <= sfla_pkg::BUMP_RST;
            heap_end_reg <= sfla_pkg::HEAP_END_RST;
        end
        else
        begin
            if (cmd.bump_take)
            begin
                bump_reg <= bump_sum[sfla_pkg::HEAP_W-1:0];
            end
            if (cfg_we)
            begin
                heap_end_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                sfla_pkg::RES_NULL:
                begin
                    res_granted_reg <= '0;
                    res_reused_reg  <= 1'b0;
                    res_status_reg  <= sfla_pkg::ST_NULL;
                end
                sfla_pkg::RES_BADLEN:
                begin
                    res_granted_reg <= '0;
                    res_reused_reg  <= 1'b0;
                    res_status_reg  <= sfla_pkg::ST_BADLEN;
                end
                sfla_pkg::RES_FULL:
                begin
                    res_granted_reg <= '0;
                    res_reused_reg  <= 1'b0;
                    res_status_reg  <= sfla_pkg::ST_FULL;
                end
                sfla_pkg::RES_BUMP:
                begin
                    res_granted_reg <= bump_reg[sfla_pkg::BLK_W-1:0];
                    res_reused_reg  <= 1'b0;
                    res_status_reg  <= sfla_pkg::ST_OK;
                end
                sfla_pkg::RES_REUSE:
                begin
                    res_granted_reg <= class_rd_reg.head;
                    res_reused_reg  <= 1'b1;
                    res_status_reg  <= sfla_pkg::ST_OK;
                end
                default:
                begin
                    res_granted_reg <= '0;
                    res_reused_reg  <= 1'b0;
                    res_status_reg  <= sfla_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            out_granted_reg <= res_granted_reg;
            out_reused_reg  <= res_reused_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign stat.clear_last = (clear_cnt_reg == AW'(NUM_CLASSES - 1));
    assign stat.is_free    = (op_reg == sfla_pkg::OP_FREE);
    assign stat.null_blk   = (block_reg == '0);
    assign stat.bad_len    = (32'(cls) >= 32'(NUM_CLASSES));
    assign stat.count_zero = (class_rd_reg.count == '0);
    assign stat.bump_fits  = (bump_sum <= SUM_W'(limit));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign granted   = out_granted_reg;
    assign reused    = out_reused_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire

// ===== sv/segregated_free_list_allocator_top.sv =====
// top level of the segregated free-list allocator; depends on sfla_pkg, sfla_ctrl, sfla_datapath
// sequence: accept, lookup, then finish for null, bad length, full and bump results; reuse passes
//   through pop and free through append between lookup and finish, for the link store read or
//   second link write; a new request is taken only in idle, or in finish once the output is free
// reset: async active low; then a clearing pass over all NUM_CLASSES class rows with in_ready low
// class table and bump pointer reset, link store contents undefined until written
`default_nettype none

module segregated_free_list_allocator_top #(
    parameter int NUM_CLASSES = sfla_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [sfla_pkg::LEN_W-1:0]    length,
    input  wire logic [sfla_pkg::BLK_W-1:0]    block,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sfla_pkg::BLK_W-1:0]         granted,
    output logic                               reused,
    output logic [1:0]                         status,
    // heap_end register write
    input  wire logic                          cfg_we,
    input  wire logic [sfla_pkg::HEAP_W-1:0]   cfg_data
);

    // command and status between controller and datapath
    sfla_pkg::dp_cmd_t  cmd;
    sfla_pkg::dp_stat_t stat;

    // controller: clear sweep, lookup, pop or append, finish
    sfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: class table, link store, bump pointer, output register
    sfla_datapath #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .length    (length),
        .block     (block),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .granted   (granted),
        .reused    (reused),
        .status    (status)
    );

`ifndef SYNTHESIS
    // an accepted request always takes at least a lookup cycle before the next one
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in the cycle after an accept");

    // failed or ignored requests never hand out a block
    a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sfla_pkg::ST_OK) |-> (granted == '0) && !reused)
        else $error("grant reported with a non-ok status");

    // a result seen once stays put until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(status))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
